[design/tgfl_pkg.sv]
package tgfl_pkg;

    // Default sizes of the texture and of the tile grid.
    localparam int TEXTURE_SIZE_DEFAULT = 256;
    localparam int MAX_TILES_DEFAULT    = 64;

    // Width of a tile coordinate on the request and result ports.
    localparam int XY_W = 6;

    // Width of the configuration address and data.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Operation codes.
    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_ALLOC   = 2'd0;
    localparam op_code_t OP_FREE    = 2'd1;
    localparam op_code_t OP_REBUILD = 2'd2;

    // Status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_EMPTY       = 2'd1;
    localparam status_t ST_DOUBLE_FREE = 2'd2;
    localparam status_t ST_OUTSIDE     = 2'd3;

    // Configuration register indexes.
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_TILE_WIDTH  = 2'd0;
    localparam reg_index_t REG_TILE_HEIGHT = 2'd1;
    localparam reg_index_t REG_PAD_PIXELS  = 2'd2;

    typedef struct packed {
        op_code_t          operation;
        logic [XY_W-1:0]   tile_x;
        logic [XY_W-1:0]   tile_y;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [XY_W-1:0]   given_x;
        logic [XY_W-1:0]   given_y;
    } result_t;

    typedef struct packed {
        logic [7:0] tile_width;
        logic [7:0] tile_height;
        logic [3:0] pad_pixels;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_cur;
        logic    cur_from_head;
        logic    pop;
        logic    push;
        logic    size_init;
        logic    size_step;
        logic    grid_load;
        logic    walk_step;
        logic    emit;
        logic    give;
        status_t emit_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_empty;
        logic in_grid;
        logic entry_taken;
        logic size_done;
        logic grid_empty;
        logic walk_last;
    } dp_stat_t;

endpackage

[design/tgfl_regs.sv]
module tgfl_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [tgfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [tgfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output tgfl_pkg::cfg_t                cfg
);
    import tgfl_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign index    = paddr[PADDR_W-1:2];
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // Register writes on the access cycle of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width  <= 8'd16;
            cfg_reg.tile_height <= 8'd16;
            cfg_reg.pad_pixels  <= 4'd1;
        end
        else if (write_en)
        begin
            case (index)
                REG_TILE_WIDTH:  cfg_reg.tile_width  <= pwdata[7:0];
                REG_TILE_HEIGHT: cfg_reg.tile_height <= pwdata[7:0];
                REG_PAD_PIXELS:  cfg_reg.pad_pixels  <= pwdata[3:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (index)
            REG_TILE_WIDTH:  prdata = PDATA_W'(cfg_reg.tile_width);
            REG_TILE_HEIGHT: prdata = PDATA_W'(cfg_reg.tile_height);
            REG_PAD_PIXELS:  prdata = PDATA_W'(cfg_reg.pad_pixels);
            default:         prdata = '0;
        endcase
    end

endmodule

[design/tgfl_ctrl.sv]
module tgfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tgfl_pkg::op_code_t  operation,
    input  tgfl_pkg::dp_stat_t  stat,
    output logic                busy,
    output tgfl_pkg::dp_cmd_t   cmd
);
    import tgfl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_PUSH = 5'b00100,
        S_SIZE = 5'b01000,
        S_WALK = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ALLOC:
                        begin
                            if (stat.head_empty)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.load_cur      = 1'b1;
                                cmd.cur_from_head = 1'b1;
                                state_next        = S_POP;
                            end
                        end
                        OP_FREE:
                        begin
                            if (!stat.in_grid)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_OUTSIDE;
                            end
                            else
                            begin
                                cmd.load_cur = 1'b1;
                                state_next   = S_PUSH;
                            end
                        end
                        OP_REBUILD:
                        begin
                            cmd.size_init = 1'b1;
                            state_next    = S_SIZE;
                        end
                        default:
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.pop         = 1'b1;
                cmd.emit        = 1'b1;
                cmd.give        = 1'b1;
                cmd.emit_status = ST_OK;
                state_next      = S_IDLE;
            end
            S_PUSH:
            begin
                cmd.emit = 1'b1;
                if (stat.entry_taken)
                begin
                    cmd.push        = 1'b1;
                    cmd.emit_status = ST_OK;
                end
                else
                begin
                    cmd.emit_status = ST_DOUBLE_FREE;
                end
                state_next = S_IDLE;
            end
            S_SIZE:
            begin
                cmd.size_step = 1'b1;
                if (stat.size_done)
                begin
                    cmd.grid_load = 1'b1;
                    if (stat.grid_empty)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/tgfl_datapath.sv]
module tgfl_datapath #(
    parameter int TEXTURE_SIZE       = tgfl_pkg::TEXTURE_SIZE_DEFAULT,
    parameter int MAX_TILES_PER_AXIS = tgfl_pkg::MAX_TILES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tgfl_pkg::cfg_t      cfg,
    input  tgfl_pkg::request_t  request,
    input  tgfl_pkg::dp_cmd_t   cmd,
    output tgfl_pkg::dp_stat_t  stat,
    output logic                result_valid,
    output tgfl_pkg::result_t   result
);
    import tgfl_pkg::*;

    localparam int CW    = $clog2(MAX_TILES_PER_AXIS);
    localparam int CNTW  = $clog2(MAX_TILES_PER_AXIS + 1);
    localparam int DEPTH = MAX_TILES_PER_AXIS * MAX_TILES_PER_AXIS;
    localparam int SW    = $clog2(DEPTH);
    localparam int HW    = 1 + 2 * CW;
    localparam int EW    = 2 + 2 * CW;
    localparam int ACCW  = $clog2(TEXTURE_SIZE + 512);
    localparam int DIVW  = 9;
    localparam int CMPW  = (CNTW > XY_W) ? CNTW : XY_W;

    localparam logic [HW-1:0] HEAD_END    = {1'b1, {(HW-1){1'b0}}};
    localparam logic [EW-1:0] ENTRY_TAKEN = {1'b1, {(EW-1){1'b0}}};

    function automatic logic [SW-1:0] slot_of(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
        return SW'(SW'(x) * SW'(MAX_TILES_PER_AXIS) + SW'(y));
    endfunction

    // Link table: {taken, end, next x, next y} per tile.
    logic [EW-1:0]   mem [DEPTH];
    logic [EW-1:0]   rd_data_reg;

    logic [HW-1:0]   head_reg;
    logic [CW-1:0]   cur_x_reg;
    logic [CW-1:0]   cur_y_reg;
    logic [CNTW-1:0] grid_across_reg;
    logic [CNTW-1:0] grid_down_reg;
    logic [ACCW-1:0] acc_a_reg;
    logic [ACCW-1:0] acc_d_reg;
    logic [CNTW-1:0] n_a_reg;
    logic [CNTW-1:0] n_d_reg;
    logic [CW-1:0]   walk_x_reg;
    logic [CW-1:0]   walk_y_reg;
    logic            result_valid_reg;
    result_t         result_reg;

    logic [CW-1:0]   cur_x_next;
    logic [CW-1:0]   cur_y_next;
    logic [SW-1:0]   rd_slot;
    logic            wr_en;
    logic [SW-1:0]   wr_slot;
    logic [EW-1:0]   wr_data;
    logic [DIVW-1:0] div_a;
    logic [DIVW-1:0] div_d;
    logic            fits_a;
    logic            fits_d;
    logic            walk_y_last;

    // Coordinates of the tile being looked up.
    always_comb
    begin
        if (cmd.cur_from_head)
        begin
            cur_x_next = head_reg[2*CW-1:CW];
            cur_y_next = head_reg[CW-1:0];
        end
        else
        begin
            cur_x_next = CW'(request.tile_x);
            cur_y_next = CW'(request.tile_y);
        end
    end

    assign rd_slot = slot_of(cur_x_next, cur_y_next);

    // Table write: taken mark on a pop, old head on a push or a rebuild step.
    assign wr_en   = cmd.pop || cmd.push || cmd.walk_step;
    assign wr_slot = cmd.walk_step ? slot_of(walk_x_reg, walk_y_reg)
                                   : slot_of(cur_x_reg, cur_y_reg);
    assign wr_data = cmd.pop ? ENTRY_TAKEN : {1'b0, head_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (cmd.load_cur)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    // Grid size by repeated addition of tile pitch, saturated to the bound.
    assign div_a  = DIVW'(cfg.tile_width) + DIVW'(cfg.pad_pixels);
    assign div_d  = DIVW'(cfg.tile_height) + DIVW'(cfg.pad_pixels);
    assign fits_a = (acc_a_reg + ACCW'(div_a) <= ACCW'(TEXTURE_SIZE))
                    && (n_a_reg < CNTW'(MAX_TILES_PER_AXIS));
    assign fits_d = (acc_d_reg + ACCW'(div_d) <= ACCW'(TEXTURE_SIZE))
                    && (n_d_reg < CNTW'(MAX_TILES_PER_AXIS));

    assign walk_y_last = (CNTW'(walk_y_reg) == grid_down_reg - CNTW'(1));

    // Status toward the controller.
    always_comb
    begin
        stat.head_empty  = head_reg[HW-1];
        stat.in_grid     = (CMPW'(request.tile_x) < CMPW'(grid_across_reg))
                           && (CMPW'(request.tile_y) < CMPW'(grid_down_reg));
        stat.entry_taken = rd_data_reg[EW-1];
        stat.size_done   = !fits_a && !fits_d;
        stat.grid_empty  = (n_a_reg == '0) || (n_d_reg == '0);
        stat.walk_last   = (CNTW'(walk_x_reg) == grid_across_reg - CNTW'(1))
                           && walk_y_last;
    end

    // List head, grid size and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= HEAD_END;
            grid_across_reg  <= '0;
            grid_down_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cmd.pop)
            begin
                head_reg <= rd_data_reg[HW-1:0];
            end
            else if (cmd.push)
            begin
                head_reg <= {1'b0, cur_x_reg, cur_y_reg};
            end
            else if (cmd.grid_load)
            begin
                head_reg <= HEAD_END;
            end
            else if (cmd.walk_step)
            begin
                head_reg <= {1'b0, walk_x_reg, walk_y_reg};
            end
            if (cmd.grid_load)
            begin
                grid_across_reg <= n_a_reg;
                grid_down_reg   <= n_d_reg;
            end
        end
    end

    // Working registers of the lookup, the sizing loop and the rebuild walk.
    always_ff @(posedge clk)
    begin
        if (cmd.load_cur)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
        if (cmd.size_init)
        begin
            acc_a_reg <= '0;
            acc_d_reg <= '0;
            n_a_reg   <= '0;
            n_d_reg   <= '0;
        end
        else if (cmd.size_step)
        begin
            if (fits_a)
            begin
                acc_a_reg <= acc_a_reg + ACCW'(div_a);
                n_a_reg   <= n_a_reg + CNTW'(1);
            end
            if (fits_d)
            begin
                acc_d_reg <= acc_d_reg + ACCW'(div_d);
                n_d_reg   <= n_d_reg + CNTW'(1);
            end
        end
        if (cmd.grid_load)
        begin
            walk_x_reg <= '0;
            walk_y_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (walk_y_last)
            begin
                walk_y_reg <= '0;
                walk_x_reg <= walk_x_reg + CW'(1);
            end
            else
            begin
                walk_y_reg <= walk_y_reg + CW'(1);
            end
        end
        if (cmd.emit)
        begin
            result_reg.status  <= cmd.emit_status;
            result_reg.given_x <= cmd.give ? XY_W'(cur_x_reg) : '0;
            result_reg.given_y <= cmd.give ? XY_W'(cur_y_reg) : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/tile_grid_free_list_top.sv]
// Tile grid free-list allocator. A request is taken when start is high and
// busy is low; its single result appears on result for exactly one cycle,
// marked by result_valid, and cannot be stalled, so the receiver must take
// it in that cycle. Allocate and free do one link-table read, then the
// write-back and head update, with the result registered; the next request
// may be issued in the cycle the result is shown. An allocate on an empty
// list, a free outside the grid and an unused operation code answer in the
// next cycle. A rebuild sizes the grid by adding the tile pitch once per
// cycle, then writes one table entry per cycle, unless the grid is empty,
// through the single table write port. The link table needs no clearing
// after reset: a rebuild writes every entry that is ever read.
// Configuration registers are to be written over the APB port only while the
// block is idle; the block itself does not enforce it.
module tile_grid_free_list_top #(
    parameter int TEXTURE_SIZE       = tgfl_pkg::TEXTURE_SIZE_DEFAULT,
    parameter int MAX_TILES_PER_AXIS = tgfl_pkg::MAX_TILES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [tgfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [tgfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          start,
    input  tgfl_pkg::request_t            request,
    output logic                          busy,
    output logic                          result_valid,
    output tgfl_pkg::result_t             result
);
    import tgfl_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration registers.
    tgfl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing of each transaction.
    tgfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Link table, list head, grid size and result register.
    tgfl_datapath #(
        .TEXTURE_SIZE       (TEXTURE_SIZE),
        .MAX_TILES_PER_AXIS (MAX_TILES_PER_AXIS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
